### hw/rtl/aotc_pkg.sv
`timescale 1ns / 1ps

package aotc_pkg;

  localparam int DROP_W = 53;
  localparam logic [22:0] GRAVITY_RESET = 23'd642908;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_STEP = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SQR   = 5'b00010,
    S_SCALE = 5'b00100,
    S_DROP  = 5'b01000,
    S_WALK  = 5'b10000
  } state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic [30:0]        size_z;
    logic               is_static;
    logic               has_mass;
  } entry_t;

  typedef struct packed {
    logic [31:0] new_z;
    logic        movable;
    logic        hit;
  } eval_t;

  function automatic logic axis_hit(input logic signed [31:0] ca, input logic [30:0] ea,
                                    input logic signed [31:0] cb, input logic [30:0] eb);
    logic signed [33:0] amin;
    logic signed [33:0] amax;
    logic signed [33:0] bmin;
    logic signed [33:0] bmax;
    amin = $signed({ca[31], ca, 1'b0}) - $signed({3'b000, ea});
    amax = $signed({ca[31], ca, 1'b0}) + $signed({3'b000, ea});
    bmin = $signed({cb[31], cb, 1'b0}) - $signed({3'b000, eb});
    bmax = $signed({cb[31], cb, 1'b0}) + $signed({3'b000, eb});
    return (amin <= bmax) && (amax >= bmin);
  endfunction

endpackage

### hw/rtl/aabb_object_table_collide.sv
`timescale 1ns / 1ps
// channel   direction  handshake                       payload
// command   in         start & !busy                   mode, pos_*, size_*, body_mass,
//                                                      is_static, time_step
// result    out        done, one cycle                 status, hit, object_count
// config    in         apb, psel & penable & pwrite    gravity at byte address 0
//
// add, unused mode and a rejected step finish straight from idle, without walking the table
// a step runs three multiply stages (S_SQR, S_SCALE, S_DROP), then walks the table one entry a cycle
// a query walks the table one entry a cycle through the table port
// the table memory has one read and one write port, read data registered
// rst is synchronous; the table holds no reset, only entries below the count are read
// the receiver cannot stall; done pulses once per item

module aabb_object_table_collide #(
  parameter int MAX_OBJECTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [30:0] size_x,
  input  logic [30:0] size_y,
  input  logic [30:0] size_z,
  input  logic [30:0] body_mass,
  input  logic        is_static,
  input  logic [31:0] time_step,
  output logic        done,
  output logic [1:0]  status,
  output logic        hit,
  output logic [7:0]  object_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import aotc_pkg::*;

  localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       ptr;
  logic [22:0]         gravity;
  logic [1:0]          mode_q;
  entry_t              qbox;
  logic [30:0]         dt;
  logic [61:0]         sq;
  logic [52:0]         ph;
  logic [54:0]         pl;
  logic [DROP_W:0]     drop_sum;
  logic [DROP_W-1:0]   drop;
  logic                rvalid;
  logic [AW-1:0]       raddr_q;
  entry_t              rdata;
  eval_t               ev;

  entry_t              mem [MAX_OBJECTS];
  logic                we;
  logic [AW-1:0]       waddr;
  entry_t              wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  logic                issue;
  logic                accept;
  logic                full;
  logic                cfg_we;

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign full         = (count >= CW'(MAX_OBJECTS));
  assign issue        = (ptr < count);
  assign re           = (state == S_WALK) && issue;
  assign raddr        = ptr[AW-1:0];
  assign object_count = 8'(count);
  assign pready       = 1'b1;
  assign cfg_we       = psel && penable && pwrite && pready && !paddr[2];
  assign prdata       = paddr[2] ? 32'd0 : {9'd0, gravity};
  assign drop_sum     = {1'b0, ph} + (DROP_W + 1)'(pl[54:32]);

  aotc_eval u_eval (
    .ent  (rdata),
    .qbox (qbox),
    .drop (drop),
    .res  (ev)
  );

  always_comb begin
    we    = 1'b0;
    waddr = raddr_q;
    wdata = rdata;
    if (accept && (mode == MODE_ADD) && !full) begin
      we              = 1'b1;
      waddr           = count[AW-1:0];
      wdata.pos_x     = pos_x;
      wdata.pos_y     = pos_y;
      wdata.pos_z     = pos_z;
      wdata.size_x    = size_x;
      wdata.size_y    = size_y;
      wdata.size_z    = size_z;
      wdata.is_static = is_static;
      wdata.has_mass  = (body_mass != 31'd0);
    end else if ((state == S_WALK) && rvalid && (mode_q == MODE_STEP) && ev.movable) begin
      we          = 1'b1;
      wdata.pos_z = ev.new_z;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata   <= mem[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= GRAVITY_RESET;
    end else if (cfg_we) begin
      gravity <= pwdata[22:0];
    end
  end

  always_ff @(posedge clk) begin
    sq <= 62'(dt) * 62'(dt);
    ph <= 53'(gravity) * 53'(sq[61:32]);
    pl <= 55'(gravity) * 55'(sq[31:0]);
    if (state == S_DROP) begin
      drop <= drop_sum[DROP_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ptr    <= '0;
      done   <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      done   <= 1'b0;
      rvalid <= re;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q         <= mode;
            qbox.pos_x     <= pos_x;
            qbox.pos_y     <= pos_y;
            qbox.pos_z     <= pos_z;
            qbox.size_x    <= size_x;
            qbox.size_y    <= size_y;
            qbox.size_z    <= size_z;
            qbox.is_static <= is_static;
            qbox.has_mass  <= 1'b0;
            dt             <= time_step[30:0];
            hit            <= 1'b0;
            status         <= ST_OK;
            ptr            <= '0;
            unique case (mode)
              MODE_ADD: begin
                done <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              MODE_STEP: begin
                if (time_step[31] || (time_step == 32'd0)) begin
                  status <= ST_BAD_STEP;
                  done   <= 1'b1;
                end else begin
                  state <= S_SQR;
                end
              end
              MODE_QUERY: begin
                state <= S_WALK;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SQR: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_DROP;
        end
        S_DROP: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          if (rvalid && (mode_q == MODE_QUERY) && ev.hit) begin
            hit <= 1'b1;
          end
          if (!issue && !rvalid) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("block left idle without an accepted item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_OBJECTS))
    else $error("object count beyond table depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while still walking the table");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("table write and read hit the same entry");

endmodule

### hw/rtl/aotc_eval.sv
`timescale 1ns / 1ps

module aotc_eval (
  input  aotc_pkg::entry_t             ent,
  input  aotc_pkg::entry_t             qbox,
  input  logic [aotc_pkg::DROP_W-1:0]  drop,
  output aotc_pkg::eval_t              res
);
  import aotc_pkg::*;

  logic signed [DROP_W+1:0] diff;
  logic signed [DROP_W+1:0] half;
  logic                     overlap;

  always_comb begin
    diff = $signed({{(DROP_W-30){ent.pos_z[31]}}, ent.pos_z}) - $signed({2'b00, drop});
    half = $signed({{(DROP_W-28){1'b0}}, ent.size_z[30:1]});
    overlap = axis_hit(qbox.pos_x, qbox.size_x, ent.pos_x, ent.size_x) &&
              axis_hit(qbox.pos_y, qbox.size_y, ent.pos_y, ent.size_y) &&
              axis_hit(qbox.pos_z, qbox.size_z, ent.pos_z, ent.size_z);
    res.movable = !ent.is_static && ent.has_mass;
    res.hit     = ent.is_static && overlap;
    if (diff < half) begin
      res.new_z = {2'b00, ent.size_z[30:1]};
    end else begin
      res.new_z = diff[31:0];
    end
  end

endmodule

### tb/aabb_object_table_collide_tb.sv
`timescale 1ns / 1ps

module aabb_object_table_collide_tb;
  import aotc_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam logic [2:0] GRAVITY_ADDR = 3'd0;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 115;
  localparam int DIRECTED_ROWS = 20;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam longint Z_FLOOR = -(longint'(1) <<< 31);
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [30:0] EXT_MAX = 31'h7fff_ffff;
  localparam logic [30:0] TWO = 31'h0002_0000;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [30:0] size_x;
    logic [30:0] size_y;
    logic [30:0] size_z;
    logic [30:0] body_mass;
    logic        is_static;
    logic [31:0] time_step;
  } command_t;

  typedef struct {
    logic [1:0] status;
    logic       hit;
    logic [7:0] count;
  } outcome_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [30:0] sx;
    logic [30:0] sy;
    logic [30:0] sz;
    logic [30:0] mass;
    logic        stat;
    logic [31:0] dt;
    bit          known;
    logic [1:0]  st;
    logic        hit;
    logic [7:0]  cnt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = '0;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [31:0] pos_z = '0;
  logic [30:0] size_x = '0;
  logic [30:0] size_y = '0;
  logic [30:0] size_z = '0;
  logic [30:0] body_mass = '0;
  logic        is_static = 1'b0;
  logic [31:0] time_step = '0;
  logic        done;
  logic [1:0]  status;
  logic        hit;
  logic [7:0]  object_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = GRAVITY_ADDR;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [22:0] gravity_cfg;
  int unsigned stored;
  longint      tab_px [TABLE_DEPTH];
  longint      tab_py [TABLE_DEPTH];
  longint      tab_pz [TABLE_DEPTH];
  longint      tab_sx [TABLE_DEPTH];
  longint      tab_sy [TABLE_DEPTH];
  longint      tab_sz [TABLE_DEPTH];
  bit          tab_static [TABLE_DEPTH];
  bit          tab_mass [TABLE_DEPTH];
  int          static_idx [$];
  outcome_t    pending_outcomes [$];
  dir_row_t    directed_rows [DIRECTED_ROWS];
  int          errors = 0;
  longint      cycles = 0;

  aabb_object_table_collide dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit axis_touch(longint ca, longint ea, longint cb, longint eb);
    return (2 * ca - ea <= 2 * cb + eb) && (2 * ca + ea >= 2 * cb - eb);
  endfunction

  function automatic outcome_t table_outcome(command_t c);
    outcome_t r;
    longint drop;
    longint z;
    longint half;
    logic [127:0] prod;
    r = '{status: ST_OK, hit: 1'b0, count: 8'd0};
    case (c.mode)
      MODE_ADD: begin
        if (stored >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tab_px[stored] = longint'($signed(c.pos_x));
          tab_py[stored] = longint'($signed(c.pos_y));
          tab_pz[stored] = longint'($signed(c.pos_z));
          tab_sx[stored] = longint'(c.size_x);
          tab_sy[stored] = longint'(c.size_y);
          tab_sz[stored] = longint'(c.size_z);
          tab_static[stored] = c.is_static;
          tab_mass[stored] = (c.body_mass != '0);
          if (c.is_static) static_idx.push_back(stored);
          stored++;
        end
      end
      MODE_STEP: begin
        if ($signed(c.time_step) <= 0) begin
          r.status = ST_BAD_STEP;
        end else begin
          prod = 128'(gravity_cfg) * 128'(c.time_step) * 128'(c.time_step);
          drop = longint'(prod >> 33);
          for (int i = 0; i < stored; i++) begin
            if (!tab_static[i] && tab_mass[i]) begin
              z = tab_pz[i] - drop;
              if (z < Z_FLOOR) z = Z_FLOOR;
              half = tab_sz[i] >>> 1;
              if (z < half) z = half;
              tab_pz[i] = z;
            end
          end
        end
      end
      MODE_QUERY: begin
        for (int i = 0; i < stored; i++) begin
          if (tab_static[i] &&
              axis_touch(longint'($signed(c.pos_x)), longint'(c.size_x), tab_px[i], tab_sx[i]) &&
              axis_touch(longint'($signed(c.pos_y)), longint'(c.size_y), tab_py[i], tab_sy[i]) &&
              axis_touch(longint'($signed(c.pos_z)), longint'(c.size_z), tab_pz[i], tab_sz[i]))
          begin
            r.hit = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = 8'(stored);
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    if (sel < 17) return $urandom;
    case ($urandom_range(0, 3))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return 32'hffff_ffff;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [30:0] rand_extent();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return 31'($urandom_range(0, 32'h0030_0000));
    if (sel < 17) return 31'($urandom);
    case ($urandom_range(0, 2))
      0: return 31'h0;
      1: return 31'h1;
      default: return EXT_MAX;
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    int unsigned sel;
    sel = $urandom_range(0, 4);
    if (sel < 2) return 31'h0;
    if (sel < 4) return 31'($urandom_range(1, 32'h0100_0000));
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] rand_step();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return 32'($urandom_range(1, 32'h0004_0000));
    if (sel < 16) return 32'($urandom_range(1, 32'h7fff_ffff));
    if (sel < 18) return $urandom | 32'h8000_0000;
    case ($urandom_range(0, 2))
      0: return 32'h0;
      1: return 32'h1;
      default: return Q_MAX;
    endcase
  endfunction

  // place a query centre around a stored box, inside or just past touching
  function automatic logic [31:0] near_coord(longint centre, longint ext_a, longint ext_b);
    longint span;
    longint off;
    span = (ext_a + ext_b) / 2;
    if (span > (longint'(1) <<< 28)) span = longint'(1) <<< 28;
    off = longint'($urandom_range(0, 32'(span * 5 / 2))) - span * 5 / 4;
    return 32'(centre + off);
  endfunction

  function automatic command_t random_command();
    command_t c;
    int unsigned pick;
    int k;
    pick = $urandom_range(0, 99);
    c.mode = pick < 25 ? MODE_ADD : pick < 48 ? MODE_STEP : pick < 95 ? MODE_QUERY : MODE_NOP;
    c.pos_x = rand_coord();
    c.pos_y = rand_coord();
    c.pos_z = rand_coord();
    c.size_x = rand_extent();
    c.size_y = rand_extent();
    c.size_z = rand_extent();
    c.body_mass = rand_mass();
    c.is_static = 1'($urandom_range(0, 1));
    c.time_step = rand_step();
    if (c.mode == MODE_QUERY && static_idx.size() > 0 && $urandom_range(0, 3) != 0) begin
      k = static_idx[$urandom_range(0, static_idx.size() - 1)];
      c.pos_x = near_coord(tab_px[k], tab_sx[k], longint'(c.size_x));
      c.pos_y = near_coord(tab_py[k], tab_sy[k], longint'(c.size_y));
      c.pos_z = near_coord(tab_pz[k], tab_sz[k], longint'(c.size_z));
    end
    return c;
  endfunction

  task automatic send_item(command_t c, int gap, bit known, outcome_t typed);
    outcome_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= c.mode;
    pos_x <= c.pos_x;
    pos_y <= c.pos_y;
    pos_z <= c.pos_z;
    size_x <= c.size_x;
    size_y <= c.size_y;
    size_z <= c.size_z;
    body_mass <= c.body_mass;
    is_static <= c.is_static;
    time_step <= c.time_step;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = table_outcome(c);
    pending_outcomes.push_back(known ? typed : predicted);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
    repeat (8) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic gravity_access(bit wr, logic [22:0] value);
    if (wr) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      pwdata <= {9'd0, value};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (pready !== 1'b1);
      gravity_cfg = value;
    end
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {9'd0, gravity_cfg}) begin
      $error("prdata: expected %h, got %h", {9'd0, gravity_cfg}, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no item pending: status %0d hit %0d object_count %0d",
               status, hit, object_count);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          errors++;
        end
        if (object_count !== want.count) begin
          $error("object_count: expected %0d, got %0d", want.count, object_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("aabb_object_table_collide_tb failed");
      $finish;
    end
  end

  initial begin
    command_t    c;
    outcome_t    typed;
    int          gap;
    logic [22:0] phase_gravity [PHASES];
    // mode, pos x y z, size x y z, mass, static, dt, known, status, hit, count
    directed_rows = '{
      '{MODE_QUERY, 0, 0, 0, TWO, TWO, TWO, 0, 0, 0, 1, ST_OK, 0, 0},
      '{MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_BAD_STEP, 0, 0},
      '{MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, Q_MIN, 1, ST_BAD_STEP, 0, 0},
      '{MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, ST_OK, 0, 0},
      '{MODE_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0},
      '{MODE_ADD, 0, 0, 0, TWO, TWO, TWO, 0, 1, 0, 1, ST_OK, 0, 1},
      '{MODE_ADD, 32'h3_0000, 0, 32'h64_0000, TWO, TWO, TWO, 31'h1_0000, 0, 0,
        1, ST_OK, 0, 2},
      '{MODE_ADD, 0, 32'h5_0000, 32'h1_0000, 31'h4_0000, 31'h4_0000, 31'h4_0000, 0, 0, 0,
        1, ST_OK, 0, 3},
      '{MODE_ADD, Q_MIN, Q_MAX, Q_MIN, EXT_MAX, EXT_MAX, EXT_MAX, EXT_MAX, 1, 0,
        1, ST_OK, 0, 4},
      '{MODE_QUERY, 32'h2_0000, 0, 0, TWO, TWO, TWO, 0, 0, 0, 1, ST_OK, 1, 4},
      '{MODE_QUERY, 32'h2_0001, 0, 0, TWO, TWO, TWO, 0, 0, 0, 0, ST_OK, 0, 0},
      '{MODE_QUERY, Q_MAX, Q_MIN, Q_MAX, EXT_MAX, EXT_MAX, EXT_MAX, EXT_MAX, 1, 32'hffff_ffff,
        0, ST_OK, 0, 0},
      '{MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, Q_MAX, 0, ST_OK, 0, 0},
      '{MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_OK, 0, 0},
      '{MODE_NOP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, EXT_MAX, EXT_MAX, EXT_MAX,
        EXT_MAX, 1, 32'hffff_ffff, 1, ST_OK, 0, 4},
      '{MODE_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, EXT_MAX, EXT_MAX, EXT_MAX,
        EXT_MAX, 0, 0, 1, ST_OK, 0, 5},
      '{MODE_ADD, 32'h1_0000, 32'h1_0000, 32'hffff_0000, 31'h8000, 31'h8000, 31'h8000, 1, 0,
        32'hffff_ffff, 1, ST_OK, 0, 6},
      '{MODE_QUERY, 0, 0, 0, 0, 0, 0, EXT_MAX, 1, 0, 1, ST_OK, 1, 6},
      '{MODE_STEP, 32'h1_0000, 0, 0, 0, 0, 0, EXT_MAX, 1, 32'h1_0000, 0, ST_OK, 0, 0},
      '{MODE_QUERY, 32'h3_0000, 0, 32'h1_0000, TWO, TWO, TWO, 0, 0, 0, 0, ST_OK, 0, 0}
    };
    phase_gravity = '{23'h40_0000, 23'h0, 23'h3f_ffff, 23'h0, 23'h1, GRAVITY_RESET};
    phase_gravity[3] = 23'($urandom_range(0, 32'h40_0000));
    gravity_cfg = GRAVITY_RESET;
    stored = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    gravity_access(1'b0, '0);

    foreach (directed_rows[i]) begin
      c.mode = directed_rows[i].mode;
      c.pos_x = directed_rows[i].px;
      c.pos_y = directed_rows[i].py;
      c.pos_z = directed_rows[i].pz;
      c.size_x = directed_rows[i].sx;
      c.size_y = directed_rows[i].sy;
      c.size_z = directed_rows[i].sz;
      c.body_mass = directed_rows[i].mass;
      c.is_static = directed_rows[i].stat;
      c.time_step = directed_rows[i].dt;
      typed = '{directed_rows[i].st, directed_rows[i].hit, directed_rows[i].cnt};
      send_item(c, $urandom_range(0, 13), directed_rows[i].known, typed);
    end

    typed = '{ST_OK, 1'b0, 8'd0};
    for (int p = 0; p < PHASES; p++) begin
      drain();
      gravity_access(1'b1, phase_gravity[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 79) == 0) drain();
        // odd phases run mostly back to back
        if (p % 2 == 1 && $urandom_range(0, 3) != 0) gap = 0;
        else gap = $urandom_range(0, 13);
        send_item(random_command(), gap, 1'b0, typed);
      end
    end

    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("aabb_object_table_collide_tb passed");
    end else begin
      $display("aabb_object_table_collide_tb failed");
    end
    $finish;
  end

endmodule
